// ===== hw/rtl/mfbre_pkg.sv =====
// Shared types, constants and command codes of the framebuffer rectangle engine.
package mfbre_pkg;
  localparam int DefWidth  = 256;
  localparam int DefHeight = 128;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_FILL   = 3'd1,
    CMD_DITHER = 3'd2,
    CMD_STROKE = 3'd3,
    CMD_INVERT = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  // Area drawing modes.
  typedef enum logic [1:0] {
    MODE_PAINT  = 2'd0,
    MODE_MID    = 2'd1,
    MODE_LIGHT  = 2'd2,
    MODE_INVERT = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        rect_w;
    logic [14:0]        rect_h;
    logic [14:0]        line_thick;
    logic               ink_black;
    logic               gray_light;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] read_bits;
    logic       op_done;
  } rsp_item_t;

  // One clipped job for the back end: row range and pixel column range, plus mode and ink.
  typedef struct packed {
    logic        is_clear;
    logic        is_read;
    logic        empty;
    mode_e       mode;
    logic        black;
    logic [12:0] r0;
    logic [12:0] r1;      // exclusive
    logic [12:0] c0;
    logic [12:0] c1;      // exclusive
    logic signed [17:0] rx;  // read start column
  } job_t;
endpackage

// ===== hw/rtl/mfbre_if.sv =====
// Valid/ready channel interfaces of the framebuffer rectangle engine.
interface mfbre_cmd_if;
  import mfbre_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfbre_rsp_if;
  import mfbre_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mfbre_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mfbre_ram #(
  parameter int DataW = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [DataW-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [DataW-1:0]         rdata
);
  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/mfbre_front.sv =====
// Front end: accept commands, clip rectangles and split strokes into jobs.
module mfbre_front #(
  parameter int Width  = mfbre_pkg::DefWidth,
  parameter int Height = mfbre_pkg::DefHeight
) (
  input  logic              clk,
  input  logic              rst_n,
  mfbre_cmd_if.sink         cmd,
  output logic              job_valid,
  output mfbre_pkg::job_t   job,
  output logic              job_last,
  input  logic              job_ready
);
  import mfbre_pkg::*;

  cmd_item_t   cur_r;
  logic        busy_r;
  logic [1:0]  part_r;
  logic        last_part;
  logic signed [17:0] ax, ay, aw, ah;
  logic signed [17:0] xe, ye;
  logic signed [17:0] c0s, c1s, r0s, r1s;
  logic        is_stroke;

  assign cmd.ready = !busy_r;
  assign is_stroke = (cur_r.cmd == CMD_STROKE);
  assign last_part = !is_stroke || (part_r == 2'd3);

  // Pick the rectangle of this part (stroke makes four bands).
  always_comb begin
    ax = 18'(cur_r.pos_x);
    ay = 18'(cur_r.pos_y);
    aw = 18'({3'b0, cur_r.rect_w});
    ah = 18'({3'b0, cur_r.rect_h});
    if (is_stroke) begin
      unique case (part_r)
        2'd0: ah = 18'({3'b0, cur_r.line_thick});
        2'd1: begin
          ah = 18'({3'b0, cur_r.line_thick});
          ay = ay + 18'({3'b0, cur_r.rect_h}) - 18'({3'b0, cur_r.line_thick});
        end
        2'd2: aw = 18'({3'b0, cur_r.line_thick});
        default: begin
          aw = 18'({3'b0, cur_r.line_thick});
          ax = ax + 18'({3'b0, cur_r.rect_w}) - 18'({3'b0, cur_r.line_thick});
        end
      endcase
    end
    xe  = ax + aw;
    ye  = ay + ah;
    c0s = (ax < 0) ? '0 : ax;
    c1s = (xe > 18'(Width)) ? 18'(Width) : xe;
    r0s = (ay < 0) ? '0 : ay;
    r1s = (ye > 18'(Height)) ? 18'(Height) : ye;
  end

  always_comb begin
    job          = '0;
    job.is_clear = (cur_r.cmd == CMD_CLEAR);
    job.is_read  = (cur_r.cmd == CMD_READ);
    job.black    = cur_r.ink_black;
    job.rx       = 18'(cur_r.pos_x);
    job.r0       = 13'(r0s);
    job.r1       = 13'(r1s);
    job.c0       = 13'(c0s);
    job.c1       = 13'(c1s);
    case (cur_r.cmd)
      CMD_DITHER: begin
        job.mode  = cur_r.gray_light ? MODE_LIGHT : MODE_MID;
        job.black = 1'b1;
      end
      CMD_INVERT: job.mode = MODE_INVERT;
      default:    job.mode = MODE_PAINT;
    endcase
    if (job.is_read) begin
      job.empty = (ay < 0) || (ay >= 18'(Height));
      job.r0    = 13'(ay);
    end else if (!job.is_clear) begin
      job.empty = (aw <= 0) || (ah <= 0) || (c0s >= c1s) || (r0s >= r1s) ||
                  (cur_r.cmd != CMD_FILL && cur_r.cmd != CMD_DITHER &&
                   cur_r.cmd != CMD_STROKE && cur_r.cmd != CMD_INVERT);
    end
  end

  assign job_valid = busy_r;
  assign job_last  = last_part;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      part_r <= '0;
    end else if (!busy_r) begin
      if (cmd.valid) begin
        busy_r <= 1'b1;
        part_r <= '0;
      end
    end else if (job_ready) begin
      if (last_part) begin
        busy_r <= 1'b0;
      end
      part_r <= part_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && cmd.valid) begin
      cur_r <= cmd.data;
    end
  end
endmodule

// ===== hw/rtl/mfbre_queue.sv =====
// Two-entry job queue between the front and back ends.
module mfbre_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mfbre_pkg::job_t in_job,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  output mfbre_pkg::job_t out_job,
  output logic            out_last,
  input  logic            out_ready
);
  import mfbre_pkg::*;

  job_t       job_r [2];
  logic [1:0] last_r;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_job   = job_r[rp_r];
  assign out_last  = last_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job_r[wp_r]  <= in_job;
      last_r[wp_r] <= in_last;
    end
  end
endmodule

// ===== hw/rtl/mfbre_back.sv =====
// Back end: clear pass, byte-wise read-modify-write of jobs, reads, responses.
module mfbre_back #(
  parameter int Width  = mfbre_pkg::DefWidth,
  parameter int Height = mfbre_pkg::DefHeight
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  mfbre_pkg::job_t job,
  input  logic            job_last,
  output logic            job_ready,
  mfbre_rsp_if.source     rsp
);
  import mfbre_pkg::*;

  localparam int Stride = (Width + 7) / 8;
  localparam int Depth  = Stride * Height;
  localparam int AW     = $clog2(Depth);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_WAIT  = 7'b0001000,
    ST_WR    = 7'b0010000,
    ST_CLEAR = 7'b0100000,
    ST_RSP   = 7'b1000000
  } state_t;

  state_t      state_r;
  job_t        job_r;
  logic        last_r;
  logic [12:0] row_r;
  logic [12:0] cb_r;     // byte column
  logic [AW-1:0] addr_r;
  logic        half_r;   // read: second byte
  logic [7:0]  pair_r;   // read: first source byte
  logic [7:0]  rbits_r;
  logic        rsp_v_r;
  logic        fill_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  mfbre_ram #(.DataW(8), .Depth(Depth)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // Row-major byte address (multiply by constant stride).
  function automatic logic [AW-1:0] addr_of(logic [12:0] r, logic [12:0] cb);
    logic [25:0] p;
    p = 26'(r) * 26'(Stride) + 26'(cb);
    return AW'(p);
  endfunction

  logic [12:0] cb_lo, cb_hi;
  logic [7:0]  mask, pat, newb;
  logic [12:0] colbase;
  logic signed [17:0] rbyte;

  assign cb_lo   = job_r.c0 >> 3;
  assign cb_hi   = (job_r.c1 - 13'd1) >> 3;
  assign colbase = {cb_r[9:0], 3'b000};
  assign rbyte   = job_r.rx >>> 3;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      logic [12:0] c;
      c = colbase + 13'(i);
      mask[7-i] = (c >= job_r.c0) && (c < job_r.c1);
      pat[7-i]  = (job_r.mode == MODE_MID) ? !(c[0] ^ row_r[0])
                                           : (!c[0] && !row_r[0]);
    end
    case (job_r.mode)
      MODE_INVERT: newb = rdata ^ mask;
      MODE_PAINT:  newb = job_r.black ? (rdata & ~mask) : (rdata | mask);
      default:     newb = rdata & ~(mask & pat);
    endcase
  end

  // Assemble the 8 read pixels from two bytes, zeroing off-screen columns.
  logic [15:0] pair_now;
  logic [7:0]  rd_bits;
  assign pair_now = {pair_r, (fill_r ? rdata : 8'h00)};
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      logic signed [17:0] sx;
      logic [3:0] off;
      sx  = job_r.rx + 18'(i);
      off = 4'(job_r.rx[2:0]) + 4'(i);
      rd_bits[7-i] = (sx >= 0) && (sx < 18'(Width)) && pair_now[15-off];
    end
  end

  assign we    = (state_r == ST_INIT) || (state_r == ST_CLEAR) ||
                 ((state_r == ST_WR) && !job_r.is_read);
  assign waddr = addr_r;
  assign wdata = (state_r == ST_WR) ? newb :
                 ((state_r == ST_CLEAR) && job_r.black) ? 8'h00 : 8'hFF;
  assign raddr = addr_r;

  assign job_ready = (state_r == ST_IDLE) && !rsp_v_r;
  assign rsp.valid = rsp_v_r;
  assign rsp.data  = '{read_bits: rbits_r, op_done: 1'b1};

  logic signed [17:0] rb_cur;
  assign rb_cur = rbyte + 18'(half_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      addr_r  <= '0;
      rsp_v_r <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp_v_r <= 1'b0;
      unique case (state_r)
        ST_INIT, ST_CLEAR: begin
          addr_r <= addr_r + AW'(1);
          if (addr_r == AW'(Depth - 1)) begin
            state_r <= (state_r == ST_INIT) ? ST_IDLE : ST_RSP;
          end
        end
        ST_IDLE: begin
          if (job_valid && !rsp_v_r) begin
            job_r  <= job;
            last_r <= job_last;
            rbits_r <= '0;
            pair_r  <= '0;
            half_r  <= 1'b0;
            row_r   <= job.r0;
            cb_r    <= job.c0 >> 3;
            if (job.is_clear) begin
              addr_r  <= '0;
              state_r <= ST_CLEAR;
            end else if (job.empty) begin
              state_r <= job_last ? ST_RSP : ST_IDLE;
            end else if (job.is_read) begin
              state_r <= ST_RD;
            end else begin
              addr_r  <= addr_of(job.r0, job.c0 >> 3);
              state_r <= ST_WAIT;
            end
          end
        end
        ST_RD: begin
          // Issue read for one of the two source bytes, if on-screen.
          if (rb_cur >= 0 && rb_cur < 18'(Stride)) begin
            addr_r  <= addr_of(row_r, 13'(rb_cur));
            fill_r  <= 1'b1;
          end else begin
            fill_r  <= 1'b0;
          end
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (job_r.is_read) begin
            state_r <= ST_WR;
          end else begin
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          if (job_r.is_read) begin
            // Collect source bytes without writing.
            if (!half_r) begin
              pair_r  <= fill_r ? rdata : 8'h00;
              half_r  <= 1'b1;
              state_r <= ST_RD;
            end else begin
              rbits_r <= rd_bits;
              rsp_v_r <= 1'b1;
              state_r <= ST_IDLE;
            end
          end else if (cb_r == cb_hi) begin
            cb_r  <= cb_lo;
            row_r <= row_r + 13'd1;
            if (row_r + 13'd1 == job_r.r1) begin
              state_r <= last_r ? ST_RSP : ST_IDLE;
            end else begin
              addr_r  <= addr_of(row_r + 13'd1, cb_lo);
              state_r <= ST_WAIT;
            end
          end else begin
            cb_r    <= cb_r + 13'd1;
            addr_r  <= addr_r + AW'(1);
            state_r <= ST_WAIT;
          end
        end
        ST_RSP: begin
          rsp_v_r <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/mono_framebuffer_rect_engine.sv =====
// Top level of the monochrome framebuffer rectangle engine.
// Operation: a fill, dither, invert or stroke reads and writes each covered byte
// (states WAIT then WR) and answers after its last band; a read fetches two source
// bytes (RD, WAIT, WR for each), skipping both when its row is off-screen;
// clear writes every byte, then answers. The back end works on one job at a time.
// Reset: synchronous rst_n; afterward a white-fill pass over every byte
// runs before the first command is carried out (commands queue meanwhile).
module mono_framebuffer_rect_engine #(
  parameter int WIDTH  = mfbre_pkg::DefWidth,
  parameter int HEIGHT = mfbre_pkg::DefHeight
) (
  input  logic        clk,
  input  logic        rst_n,
  mfbre_cmd_if.sink   in_cmd,
  mfbre_rsp_if.source out_rsp
);
  import mfbre_pkg::*;

  // Front to queue.
  logic f_valid, f_last, f_ready;
  job_t f_job;
  // Queue to back.
  logic b_valid, b_last, b_ready;
  job_t b_job;

  // Clip and split requests into row and column range jobs.
  mfbre_front #(.Width(WIDTH), .Height(HEIGHT)) u_front (
    .clk, .rst_n, .cmd(in_cmd),
    .job_valid(f_valid), .job(f_job), .job_last(f_last), .job_ready(f_ready)
  );

  // Decouple classification from the memory walk.
  mfbre_queue u_queue (
    .clk, .rst_n,
    .in_valid(f_valid), .in_job(f_job), .in_last(f_last), .in_ready(f_ready),
    .out_valid(b_valid), .out_job(b_job), .out_last(b_last), .out_ready(b_ready)
  );

  // Walk the framebuffer and answer each request once.
  mfbre_back #(.Width(WIDTH), .Height(HEIGHT)) u_back (
    .clk, .rst_n,
    .job_valid(b_valid), .job(b_job), .job_last(b_last), .job_ready(b_ready),
    .rsp(out_rsp)
  );
endmodule

// ===== hw/rtl/mfbre_checker.sv =====
// Port-level checker of the framebuffer rectangle engine, bound to the top.
module mfbre_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_done
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("response dropped");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_done) else $error("op_done low");
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("response after reset");
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("front took two back to back");
endmodule

bind mono_framebuffer_rect_engine mfbre_checker u_checker (
  .clk, .rst_n,
  .in_valid(in_cmd.valid), .in_ready(in_cmd.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
  .out_done(out_rsp.data.op_done)
);

// ===== tb/mono_framebuffer_rect_engine_tb.sv =====
// Testbench of the monochrome framebuffer rectangle engine: directed and random requests.
module mono_framebuffer_rect_engine_tb;
  import mfbre_pkg::*;

  localparam int FbW      = DefWidth;
  localparam int FbH      = DefHeight;
  localparam int Stride   = (FbW + 7) / 8;
  localparam int IdleLim  = 200000;

  logic clk;
  logic rst_n;

  mfbre_cmd_if cmd_ch ();
  mfbre_rsp_if rsp_ch ();

  mono_framebuffer_rect_engine uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_ch.sink),
    .out_rsp (rsp_ch.source)
  );

  // Shadow copy of the framebuffer, one bit per pixel: 1 is white.
  logic      shadow_px [FbH][FbW];
  rsp_item_t rsp_queue [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          mismatches;
  int          rsp_seen;
  int          idle_cycles;
  int          n_reqs;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Paint one clipped area. kind: PAINT colour, MID/LIGHT dither, INVERT xor.
  task automatic shade_area(int x, int y, int w, int h, mode_e kind, bit black);
    int c0, c1, r0, r1;
    if (w <= 0 || h <= 0) return;
    c0 = (x < 0) ? 0 : x;
    r0 = (y < 0) ? 0 : y;
    c1 = (x + w > FbW) ? FbW : x + w;
    r1 = (y + h > FbH) ? FbH : y + h;
    for (int r = r0; r < r1; r++) begin
      for (int c = c0; c < c1; c++) begin
        case (kind)
          MODE_INVERT: shadow_px[r][c] = ~shadow_px[r][c];
          MODE_PAINT:  shadow_px[r][c] = ~black;
          MODE_MID: begin
            if (((c ^ r) & 1) == 0) shadow_px[r][c] = 1'b0;
          end
          default: begin
            if ((c & 1) == 0 && (r & 1) == 0) shadow_px[r][c] = 1'b0;
          end
        endcase
      end
    end
  endtask

  // Apply one command to the shadow buffer and queue the response it must give.
  task automatic predict_framebuffer(cmd_item_t it);
    rsp_item_t rsp;
    int x, y, w, h, t;
    x = int'(it.pos_x);
    y = int'(it.pos_y);
    w = int'(it.rect_w);
    h = int'(it.rect_h);
    t = int'(it.line_thick);
    rsp.read_bits = 8'h00;
    rsp.op_done   = 1'b1;
    case (it.cmd)
      CMD_CLEAR: begin
        foreach (shadow_px[r, c]) shadow_px[r][c] = ~it.ink_black;
      end
      CMD_FILL:   shade_area(x, y, w, h, MODE_PAINT, it.ink_black);
      CMD_DITHER: shade_area(x, y, w, h, it.gray_light ? MODE_LIGHT : MODE_MID, 1'b1);
      CMD_STROKE: begin
        shade_area(x, y, w, t, MODE_PAINT, it.ink_black);
        shade_area(x, y + h - t, w, t, MODE_PAINT, it.ink_black);
        shade_area(x, y, t, h, MODE_PAINT, it.ink_black);
        shade_area(x + w - t, y, t, h, MODE_PAINT, it.ink_black);
      end
      CMD_INVERT: shade_area(x, y, w, h, MODE_INVERT, 1'b0);
      CMD_READ: begin
        if (y >= 0 && y < FbH) begin
          for (int i = 0; i < 8; i++) begin
            if (x + i >= 0 && x + i < FbW) rsp.read_bits[7 - i] = shadow_px[y][x + i];
          end
        end
      end
      default: ;
    endcase
    rsp_queue.push_back(rsp);
  endtask

  // Offer one request, hold it until accepted, then predict its response.
  task automatic send_request(cmd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= it;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_framebuffer(it);
    n_reqs++;
  endtask

  function automatic cmd_item_t make_req(cmd_e op, int x, int y, int w, int h, int t,
                                         bit black, bit light);
    cmd_item_t it;
    it.cmd        = op;
    it.pos_x      = 16'(x);
    it.pos_y      = 16'(y);
    it.rect_w     = 15'(w);
    it.rect_h     = 15'(h);
    it.line_thick = 15'(t);
    it.ink_black  = black;
    it.gray_light = light;
    return it;
  endfunction

  // Random coordinate: mostly near the screen, sometimes anywhere.
  function automatic int rand_coord(int lim);
    if ($urandom_range(9) == 0) return int'($signed(16'($urandom())));
    return int'($urandom_range(lim + 24)) - 16;
  endfunction

  function automatic int rand_len(int lim);
    case ($urandom_range(9))
      0:       return $urandom_range(32767);
      1:       return 0;
      default: return $urandom_range(lim / 3);
    endcase
  endfunction

  // Accept responses and compare each with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen++;
      if (rsp_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp_ch.data);
      end else begin
        if (rsp_ch.data !== rsp_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d: expected bits %h done %b, got bits %h done %b",
                     rsp_seen, rsp_queue[0].read_bits, rsp_queue[0].op_done,
                     rsp_ch.data.read_bits, rsp_ch.data.op_done);
        end
        void'(rsp_queue.pop_front());
      end
    end
  end

  // Stall the response side at the current rate.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLim) begin
      $display("watchdog expired after %0d requests", n_reqs);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Extremes of every field and every command, with reads in between.
  task automatic test_directed();
    send_request(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_FILL, -32768, -32768, 32767, 32767, 0, 1, 0));
    send_request(make_req(CMD_READ, -4, 5, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_FILL, 3, 2, 10, 4, 0, 1, 1));
    send_request(make_req(CMD_FILL, 5, 3, 0, 4, 0, 1, 0));
    send_request(make_req(CMD_READ, 0, 3, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_DITHER, 20, 10, 12, 3, 0, 0, 0));
    send_request(make_req(CMD_DITHER, 40, 10, 12, 3, 0, 0, 1));
    send_request(make_req(CMD_READ, 20, 11, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_READ, 40, 10, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_STROKE, 60, 20, 20, 10, 2, 1, 0));
    send_request(make_req(CMD_STROKE, 100, 20, 4, 4, 9, 1, 0));
    send_request(make_req(CMD_STROKE, 90, 20, 8, 8, 0, 1, 0));
    send_request(make_req(CMD_READ, 60, 21, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_INVERT, 250, 120, 100, 100, 0, 0, 0));
    send_request(make_req(CMD_READ, 250, 127, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_READ, 32767, 32767, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_READ, 0, -1, 0, 0, 0, 0, 0));
    send_request(make_req(cmd_e'(3'd6), 0, 0, 32767, 32767, 32767, 1, 1));
    send_request(make_req(cmd_e'(3'd7), 0, 0, 100, 100, 0, 1, 0));
    send_request(make_req(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0));
    send_request(make_req(CMD_READ, 248, 0, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_FILL, 0, 0, 32767, 32767, 32767, 0, 0));
  endtask

  // Random mix: half reads, the rest drawing, clear and unused codes.
  task automatic test_random(int count);
    cmd_item_t   it;
    logic [95:0] raw;
    for (int i = 0; i < count; i++) begin
      raw = {$urandom(), $urandom(), $urandom()};
      it = raw[$bits(cmd_item_t)-1:0];
      it.pos_x  = 16'(rand_coord(FbW));
      it.pos_y  = 16'(rand_coord(FbH));
      it.rect_w = 15'(rand_len(FbW));
      it.rect_h = 15'(rand_len(FbH));
      it.line_thick = ($urandom_range(7) == 0) ? 15'($urandom_range(32767))
                                               : 15'($urandom_range(6));
      case ($urandom_range(19))
        0:           it.cmd = ($urandom_range(3) == 0) ? cmd_e'(3'd6 + $urandom_range(1))
                                                       : CMD_CLEAR;
        1, 2, 3:     it.cmd = CMD_FILL;
        4, 5:        it.cmd = CMD_DITHER;
        6, 7:        it.cmd = CMD_STROKE;
        8, 9:        it.cmd = CMD_INVERT;
        default:     it.cmd = CMD_READ;
      endcase
      send_request(it);
    end
  endtask

  initial begin
    clk           = 1'b0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.data   = '0;
    rsp_ch.ready  = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 46;
    mismatches    = 0;
    rsp_seen      = 0;
    idle_cycles   = 0;
    n_reqs        = 0;
    foreach (shadow_px[r, c]) shadow_px[r][c] = 1'b1;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(240);
    send_idle_pct = 46;
    recv_idle_pct = 18;
    test_random(240);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    cmd_ch.valid <= 1'b0;

    // Drain outstanding responses, then let the back end settle.
    while (rsp_queue.size() != 0) @(posedge clk);
    repeat (Stride * FbH + 16) @(posedge clk);

    $display("covered %0d requests: clear, fill, dither, stroke, invert, read, unused codes",
             n_reqs);
    $display("responses checked %0d, mismatching %0d", rsp_seen, mismatches);
    if (mismatches == 0 && rsp_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/mfbre_pkg.sv
hw/rtl/mfbre_if.sv
hw/rtl/mfbre_ram.sv
hw/rtl/mfbre_front.sv
hw/rtl/mfbre_queue.sv
hw/rtl/mfbre_back.sv
hw/rtl/mono_framebuffer_rect_engine.sv
hw/rtl/mfbre_checker.sv
tb/mono_framebuffer_rect_engine_tb.sv
